>>> rtl/discovery_entity_table_assert.svh
// -----------------------------------------------------------------------------
// Discovery entity table assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// -----------------------------------------------------------------------------
`ifndef DISCOVERY_ENTITY_TABLE_ASSERT_SVH
`define DISCOVERY_ENTITY_TABLE_ASSERT_SVH

// check a property on every rising edge outside reset
`define DET_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("discovery entity table check failed");

// check that a condition never holds outside reset
`define DET_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("discovery entity table forbidden condition");

`endif

>>> rtl/det_pkg.sv
// -----------------------------------------------------------------------------
// Discovery entity table package
// Request and result types, event codes and register indexes.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package det_pkg;

	localparam int ID_W       = 64;
	localparam int SLOT_W     = 6;
	localparam int TIME_W     = 18;
	localparam int STEP_W     = 12;
	localparam int GRACE_W    = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [7:0] ADP_SUBTYPE = 8'hfa;

	localparam logic REQ_FRAME = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	localparam logic [3:0] MSG_AVAILABLE = 4'd0;
	localparam logic [3:0] MSG_DEPARTING = 4'd1;

	localparam logic [2:0] EV_UPDATED  = 3'd0;
	localparam logic [2:0] EV_ADDED    = 3'd1;
	localparam logic [2:0] EV_DEPARTED = 3'd2;
	localparam logic [2:0] EV_DROPPED  = 3'd3;
	localparam logic [2:0] EV_IGNORED  = 3'd4;
	localparam logic [2:0] EV_TIMEOUT  = 3'd5;
	localparam logic [2:0] EV_QUIET    = 3'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_GRACE = CFG_IDX_W'(1);

	localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(2000);
	localparam logic [GRACE_W-1:0] GRACE_RESET = '0;

	typedef struct packed {
		logic             req_type;
		logic [7:0]       subtype;
		logic [3:0]       msg_kind;
		logic [ID_W-1:0]  entity_id;
		logic [4:0]       valid_time;
		logic [15:0]      elapsed_ms;
	} cmd_t;

	typedef struct packed {
		logic [2:0]        event_res;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   slot_id;
		logic              last;
	} result_t;

endpackage

>>> rtl/discovery_entity_table.sv
// -----------------------------------------------------------------------------
// Discovery entity table
// Tracks discovered entities by id with a per-slot countdown; frames add or
// refresh slots, ticks count valid slots down and report expiries.
// -----------------------------------------------------------------------------
//  channel   | signals                          | handshake
//  ----------+----------------------------------+--------------------------------
//  request   | cmd                              | start & !busy
//  result    | result                           | result_valid, one cycle
//  config    | cfg_index, cfg_data              | cfg_valid & cfg_ready
//
// A tick or a handled frame scans the occupied slots through one read port of
// the id and countdown memories, one slot per cycle. A tick or a frame miss
// keeps busy high until every occupied slot has been read; a frame hit ends the
// scan at the matching slot. The final result shows in the first cycle with
// busy low. An ignored frame answers the cycle after start with busy staying
// low. Reset clears the valid bits and the fill count at once; there is no
// clearing pass. The result side cannot stall.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module discovery_entity_table import det_pkg::*; #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  cmd_t                  cmd,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  result_valid,
	output result_t               result
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);

	typedef enum logic {ST_IDLE, ST_SCAN} state_t;

	state_t                  state_q;
	logic [STEP_W-1:0]       step_q;
	logic [GRACE_W-1:0]      grace_q;
	cmd_t                    cmd_q;
	logic [TIME_W-1:0]       reload_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        rd_idx_q;
	logic [MAX_ENTRIES-1:0]  valid_q;
	logic                    vld_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic                    pend_vld_q;
	logic [IDX_W-1:0]        pend_idx_q;
	logic [ID_W-1:0]         pend_id_q;

	logic [ID_W-1:0]         id_mem [MAX_ENTRIES];
	logic [TIME_W-1:0]       time_mem [MAX_ENTRIES];
	logic [ID_W-1:0]         id_rd_s1;
	logic [TIME_W-1:0]       time_rd_s1;

	logic                    rd_more;
	logic                    scan_end;
	logic                    is_tick;
	logic                    entry_live;
	logic                    expire;
	logic                    frame_hit;
	logic                    frame_miss;
	logic                    table_full;
	logic                    new_valid;
	logic                    departing;
	logic [IDX_W-1:0]        new_idx;
	logic                    id_we;
	logic                    time_we;
	logic [IDX_W-1:0]        time_waddr;
	logic [TIME_W-1:0]       time_wdata;
	logic                    foreign;

	function automatic result_t make_result(logic [2:0] ev, logic [IDX_W-1:0] idx,
			logic [ID_W-1:0] id, logic fin);
		result_t r;
		r.event_res = ev;
		r.slot      = SLOT_W'(idx);
		r.slot_id   = id;
		r.last      = fin;
		return r;
	endfunction

	assign cfg_ready = 1'b1;

	always_comb begin
		foreign    = (cmd.subtype != ADP_SUBTYPE) || (cmd.msg_kind > MSG_DEPARTING);
		rd_more    = rd_idx_q < count_q;
		scan_end   = !rd_more && !vld_s1;
		is_tick    = cmd_q.req_type == REQ_TICK;
		entry_live = vld_s1 && valid_q[idx_s1];
		expire     = is_tick && entry_live && (time_rd_s1 <= TIME_W'(cmd_q.elapsed_ms));
		frame_hit  = !is_tick && vld_s1 && (id_rd_s1 == cmd_q.entity_id);
		frame_miss = !is_tick && scan_end;
		table_full = count_q == FULL_CNT;
		departing  = cmd_q.msg_kind == MSG_DEPARTING;
		new_valid  = cmd_q.msg_kind == MSG_AVAILABLE;
		new_idx    = count_q[IDX_W-1:0];

		id_we   = (state_q == ST_SCAN) && frame_miss && !table_full;
		time_we = (state_q == ST_SCAN) && (frame_hit || (frame_miss && !table_full)
			|| (is_tick && entry_live && !expire));
		time_waddr = (frame_miss) ? new_idx : idx_s1;
		time_wdata = is_tick ? (time_rd_s1 - TIME_W'(cmd_q.elapsed_ms)) : reload_q;
	end

	always_ff @(posedge clk) begin
		if (id_we) begin
			id_mem[new_idx] <= cmd_q.entity_id;
		end
		if (time_we) begin
			time_mem[time_waddr] <= time_wdata;
		end
		id_rd_s1   <= id_mem[rd_idx_q[IDX_W-1:0]];
		time_rd_s1 <= time_mem[rd_idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_RESET;
			grace_q <= GRACE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STEP:  step_q  <= cfg_data[STEP_W-1:0];
				CFG_GRACE: grace_q <= cfg_data[GRACE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			busy         <= 1'b0;
			result_valid <= 1'b0;
			result       <= '0;
			cmd_q        <= '0;
			reload_q     <= '0;
			count_q      <= '0;
			rd_idx_q     <= '0;
			valid_q      <= '0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			pend_vld_q   <= 1'b0;
			pend_idx_q   <= '0;
			pend_id_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					result_valid <= start && cmd.req_type == REQ_FRAME && foreign;
					if (start) begin
						cmd_q      <= cmd;
						reload_q   <= TIME_W'(TIME_W'(cmd.valid_time) * TIME_W'(step_q)
							+ TIME_W'(grace_q));
						rd_idx_q   <= '0;
						vld_s1     <= 1'b0;
						pend_vld_q <= 1'b0;
						if (cmd.req_type == REQ_FRAME && foreign) begin
							result <= make_result(EV_IGNORED, '0, '0, 1'b1);
						end else begin
							state_q <= ST_SCAN;
							busy    <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					vld_s1       <= rd_more && !frame_hit;
					result_valid <= scan_end || frame_hit || (expire && pend_vld_q);
					if (rd_more && !frame_hit) begin
						idx_s1   <= rd_idx_q[IDX_W-1:0];
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (is_tick) begin
						if (expire) begin
							valid_q[idx_s1] <= 1'b0;
							pend_vld_q      <= 1'b1;
							pend_idx_q      <= idx_s1;
							pend_id_q       <= id_rd_s1;
							if (pend_vld_q) begin
								result <= make_result(EV_TIMEOUT, pend_idx_q, pend_id_q, 1'b0);
							end
						end
						if (scan_end) begin
							state_q <= ST_IDLE;
							busy    <= 1'b0;
							if (pend_vld_q) begin
								result <= make_result(EV_TIMEOUT, pend_idx_q, pend_id_q, 1'b1);
							end else begin
								result <= make_result(EV_QUIET, '0, '0, 1'b1);
							end
						end
					end else if (frame_hit) begin
						valid_q[idx_s1] <= new_valid;
						state_q         <= ST_IDLE;
						busy            <= 1'b0;
						result <= make_result(departing ? EV_DEPARTED : EV_UPDATED, idx_s1,
							cmd_q.entity_id, 1'b1);
					end else if (frame_miss) begin
						state_q <= ST_IDLE;
						busy    <= 1'b0;
						if (table_full) begin
							result <= make_result(EV_DROPPED, '0, '0, 1'b1);
						end else begin
							valid_q[new_idx] <= new_valid;
							count_q          <= count_q + CNT_W'(1);
							result <= make_result(departing ? EV_DEPARTED : EV_ADDED, new_idx,
								cmd_q.entity_id, 1'b1);
						end
					end
				end
				default: begin
					state_q      <= ST_IDLE;
					busy         <= 1'b0;
					result_valid <= 1'b0;
				end
			endcase
		end
	end

endmodule

>>> rtl/det_checker.sv
// -----------------------------------------------------------------------------
// Discovery entity table checker
// Port-level checks on request, busy and result sequencing.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "discovery_entity_table_assert.svh"

module det_checker import det_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input cmd_t    cmd,
	input logic    result_valid,
	input result_t result
);

	logic foreign_acc;
	logic quiet_res;

	assign foreign_acc = start && !busy && cmd.req_type == REQ_FRAME
		&& cmd.subtype != ADP_SUBTYPE;
	assign quiet_res   = result_valid && result.event_res == EV_QUIET;

	`DET_ASSERT(a_tick_goes_busy, start && !busy && cmd.req_type == REQ_TICK |=> busy)
	`DET_ASSERT(a_idle_result_last, result_valid && !busy |-> result.last)
	`DET_ASSERT(a_busy_fall_last, $fell(busy) |-> result_valid && result.last)
	`DET_ASSERT(a_quiet_empty, quiet_res |-> result.slot == '0 && result.slot_id == '0 && result.last)
	`DET_NEVER(a_foreign_busy, $past(foreign_acc) && busy)

endmodule

bind discovery_entity_table det_checker u_det_checker (.*);
